// ===== rtl/tbs_pkg.sv =====
// Shared types and fixed widths of the truss bar stiffness pipeline.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package tbs_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int L2_W       = SQ_W + 2;
    localparam int SQRT_XBITS = 16;
    localparam int X_W        = L2_W + 2 * SQRT_XBITS;
    localparam int ROOT_W     = 49;
    localparam int EA_W       = 64;
    localparam int NUMP_W     = EA_W + SQ_W;
    localparam int DEN_W      = L2_W + ROOT_W;
    localparam int QBITS      = 64;
    localparam int COEF_W     = 64;
    localparam int NUM_COEF   = 6;
    localparam int MUL_LAT    = 3;
    localparam int PIPE_LAT   = 3 + ROOT_W + MUL_LAT + 1 + QBITS + 1;

    // coefficient lanes
    localparam int LANE_XX = 0;
    localparam int LANE_YY = 1;
    localparam int LANE_ZZ = 2;
    localparam int LANE_XY = 3;
    localparam int LANE_XZ = 4;
    localparam int LANE_YZ = 5;

    typedef struct packed {
        logic signed [COORD_W-1:0] end_a_x;
        logic signed [COORD_W-1:0] end_a_y;
        logic signed [COORD_W-1:0] end_a_z;
        logic signed [COORD_W-1:0] end_b_x;
        logic signed [COORD_W-1:0] end_b_y;
        logic signed [COORD_W-1:0] end_b_z;
        logic        [COORD_W-1:0] modulus;
        logic        [COORD_W-1:0] area;
    } t_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] coef_zz;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] coef_xz;
        logic signed [COEF_W-1:0] coef_yz;
        logic                     zero_length;
        logic                     saturated;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/tbs_delay.sv =====
// Delay line with a valid bit for side data that rides beside a long unit.
// Depends on nothing.
`default_nettype none

module tbs_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_data [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_data[k] <= r_data[k-1];
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/tbs_wmul.sv =====
// Wide unsigned multiplier cut into four partial products, three stages.
// Depends on nothing.
`default_nettype none

module tbs_wmul #(
    parameter int A_W = 64,
    parameter int B_W = 64
) (
    input  wire logic               i_clk,
    input  wire logic [A_W-1:0]     i_a,
    input  wire logic [B_W-1:0]     i_b,
    output logic      [A_W+B_W-1:0] o_p
);

    localparam int AL  = A_W / 2;
    localparam int AH  = A_W - AL;
    localparam int BL  = B_W / 2;
    localparam int BH  = B_W - BL;
    localparam int P_W = A_W + B_W;

    logic [AL-1:0] a_lo;
    logic [AH-1:0] a_hi;
    logic [BL-1:0] b_lo;
    logic [BH-1:0] b_hi;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [P_W-1:0]   r_s0;
    logic [P_W-1:0]   r_s1;
    logic [P_W-1:0]   r_p;

    assign a_lo = i_a[AL-1:0];
    assign a_hi = i_a[A_W-1:AL];
    assign b_lo = i_b[BL-1:0];
    assign b_hi = i_b[B_W-1:BL];

    always_ff @(posedge i_clk) begin
        r_ll <= (AL+BL)'(a_lo) * (AL+BL)'(b_lo);
        r_lh <= (AL+BH)'(a_lo) * (AL+BH)'(b_hi);
        r_hl <= (AH+BL)'(a_hi) * (AH+BL)'(b_lo);
        r_hh <= (AH+BH)'(a_hi) * (AH+BH)'(b_hi);
        r_s0 <= P_W'(r_ll) + (P_W'(r_lh) << BL);
        r_s1 <= P_W'(r_hl) + (P_W'(r_hh) << BL);
        r_p  <= r_s0 + (r_s1 << AL);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/tbs_sqrt.sv =====
// Pipelined integer square root of the squared length with extra fraction
// bits, one root bit per stage. Depends on tbs_pkg.
`default_nettype none

module tbs_sqrt (
    input  wire logic                         i_clk,
    input  wire logic [tbs_pkg::L2_W-1:0]     i_l2,
    output logic      [tbs_pkg::ROOT_W-1:0]   o_root
);

    localparam int X_W    = tbs_pkg::X_W;
    localparam int ROOT_W = tbs_pkg::ROOT_W;
    localparam int T_W    = X_W + 2;

    logic [X_W-1:0]    x;
    logic [X_W-1:0]    r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    assign x = {i_l2, {(2 * tbs_pkg::SQRT_XBITS){1'b0}}};

    // rem holds x - root^2; accept a bit when 2^(b+1)*root + 2^(2b) fits
    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic [X_W-1:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [T_W-1:0]    trial;
        logic              take;

        if (j == 0) begin : g_first
            assign rem_in  = x;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign trial = (T_W'(root_in) << (B + 1)) | (T_W'(1) << (2 * B));
        assign take  = T_W'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            r_root[j] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
        end

        if (j < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[j] <= take ? (rem_in - trial[X_W-1:0]) : rem_in;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/tbs_div.sv =====
// Six-lane pipelined restoring divider sharing one denominator, one quotient
// bit per stage, with overflow check and saturating output. Depends on tbs_pkg.
`default_nettype none

module tbs_div #(
    parameter int SHIFT = 32
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_valid,
    input  wire logic [tbs_pkg::NUM_COEF-1:0][tbs_pkg::NUMP_W-1:0] i_num,
    input  wire logic [tbs_pkg::DEN_W-1:0]                         i_den,
    input  wire logic [tbs_pkg::NUM_COEF-1:0]                      i_neg,
    input  wire logic                                              i_zero,
    output logic                                                   o_valid,
    output tbs_pkg::t_result                                       o_result
);

    localparam int QBITS  = tbs_pkg::QBITS;
    localparam int NC     = tbs_pkg::NUM_COEF;
    localparam int COEF_W = tbs_pkg::COEF_W;
    localparam int NUM_W  = tbs_pkg::NUMP_W + SHIFT;
    localparam int CMP_W  = (NUM_W > tbs_pkg::DEN_W + QBITS) ?
                            NUM_W : tbs_pkg::DEN_W + QBITS;

    logic [NUM_W-1:0]          r_rem  [QBITS][NC];
    logic [QBITS-1:0]          r_quo  [QBITS][NC];
    logic [tbs_pkg::DEN_W-1:0] r_den  [QBITS];
    logic [NC-1:0]             r_ovf  [QBITS+1];
    logic [NC-1:0]             r_neg  [QBITS+1];
    logic                      r_zero [QBITS+1];
    logic [QBITS:0]            r_valid;

    logic [COEF_W-1:0]         n_coef [NC];
    logic [NC-1:0]             n_sat;
    tbs_pkg::t_result          n_res;
    tbs_pkg::t_result          r_res;
    logic                      r_out_valid;

    // entry stage: scale numerators, flag quotients of 2^64 or more
    for (genvar l = 0; l < NC; l++) begin : g_entry
        logic [NUM_W-1:0] num_s;
        assign num_s = {i_num[l], {SHIFT{1'b0}}};
        always_ff @(posedge i_clk) begin
            r_rem[0][l] <= num_s;
            r_ovf[0][l] <= CMP_W'(num_s) >= (CMP_W'(i_den) << QBITS);
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0]  <= i_den;
        r_neg[0]  <= i_neg;
        r_zero[0] <= i_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid[0] <= i_valid;
            for (int s = 1; s <= QBITS; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    for (genvar j = 1; j <= QBITS; j++) begin : g_step
        localparam int K = QBITS - j;

        for (genvar l = 0; l < NC; l++) begin : g_lane
            logic [CMP_W-1:0] trial;
            logic             take;
            logic [QBITS-1:0] quo_in;

            assign trial = CMP_W'(r_den[j-1]) << K;
            assign take  = CMP_W'(r_rem[j-1][l]) >= trial;

            if (j == 1) begin : g_q0
                assign quo_in = '0;
            end else begin : g_qn
                assign quo_in = r_quo[j-2][l];
            end

            always_ff @(posedge i_clk) begin
                r_quo[j-1][l] <= {quo_in[QBITS-2:0], take};
            end

            if (j < QBITS) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_rem[j][l] <= take ? NUM_W'(CMP_W'(r_rem[j-1][l]) - trial)
                                        : r_rem[j-1][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_ovf[j]  <= r_ovf[j-1];
            r_neg[j]  <= r_neg[j-1];
            r_zero[j] <= r_zero[j-1];
        end

        if (j < QBITS) begin : g_den
            always_ff @(posedge i_clk) begin
                r_den[j] <= r_den[j-1];
            end
        end
    end

    // clamp to the signed range, negate when the lane is negative, zero every lane of a zero-length bar
    always_comb begin
        logic [QBITS-1:0] q;
        for (int l = 0; l < NC; l++) begin
            q = r_quo[QBITS-1][l];
            if (r_zero[QBITS]) begin
                n_coef[l] = '0;
                n_sat[l]  = 1'b0;
            end else if (!r_neg[QBITS][l]) begin
                if (r_ovf[QBITS][l] || q[QBITS-1]) begin
                    n_coef[l] = {1'b0, {(COEF_W-1){1'b1}}};
                    n_sat[l]  = 1'b1;
                end else begin
                    n_coef[l] = q;
                    n_sat[l]  = 1'b0;
                end
            end else begin
                if (r_ovf[QBITS][l] || (q[QBITS-1] && (|q[QBITS-2:0]))) begin
                    n_coef[l] = {1'b1, {(COEF_W-1){1'b0}}};
                    n_sat[l]  = 1'b1;
                end else begin
                    n_coef[l] = ~q + COEF_W'(1);
                    n_sat[l]  = 1'b0;
                end
            end
        end
        n_res.coef_xx     = n_coef[tbs_pkg::LANE_XX];
        n_res.coef_yy     = n_coef[tbs_pkg::LANE_YY];
        n_res.coef_zz     = n_coef[tbs_pkg::LANE_ZZ];
        n_res.coef_xy     = n_coef[tbs_pkg::LANE_XY];
        n_res.coef_xz     = n_coef[tbs_pkg::LANE_XZ];
        n_res.coef_yz     = n_coef[tbs_pkg::LANE_YZ];
        n_res.zero_length = r_zero[QBITS];
        n_res.saturated   = |n_sat;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid[QBITS];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== rtl/truss_bar_stiffness.sv =====
// Top level: 3D truss bar stiffness coefficients k*di*dj, k = E*A/L^3.
// Depends on tbs_pkg, tbs_sqrt, tbs_wmul, tbs_delay and tbs_div.
//
//  channel  | signals                  | handshake
//  ---------+--------------------------+------------------------------------
//  request  | start, i_item, busy      | taken when start high and busy low
//  result   | o_valid, o_result        | one-cycle strobe, cannot be held off
//
// A request enters every cycle; busy stays low. The pipeline holds 3 front
// stages, 49 square root stages, 3 multiplier stages, an overflow check,
// 64 divider stages and the output register. The square root and the
// 64-bit quotient set the depth. Synchronous reset clears all valid bits and
// drops requests in flight; there is no clearing pass and nothing stalls.
`default_nettype none

module truss_bar_stiffness #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire tbs_pkg::t_item i_item,
    output logic                busy,
    output logic                o_valid,
    output tbs_pkg::t_result    o_result
);

    localparam int DIFF_W = tbs_pkg::DIFF_W;
    localparam int MAG_W  = tbs_pkg::MAG_W;
    localparam int SQ_W   = tbs_pkg::SQ_W;
    localparam int L2_W   = tbs_pkg::L2_W;
    localparam int EA_W   = tbs_pkg::EA_W;
    localparam int NC     = tbs_pkg::NUM_COEF;
    localparam int SHIFT  = FRAC_BITS + tbs_pkg::SQRT_XBITS;

    typedef struct packed {
        logic [L2_W-1:0]          l2;
        logic [EA_W-1:0]          ea;
        logic [NC-1:0][SQ_W-1:0]  p;
        logic [NC-1:0]            neg;
        logic                     zero;
    } t_side;

    typedef struct packed {
        logic [NC-1:0] neg;
        logic          zero;
    } t_tail;

    logic                     r_s1_valid;
    logic signed [DIFF_W-1:0] r_s1_d [3];
    logic [EA_W-1:0]          r_s1_ea;

    logic [MAG_W-1:0]         mag [3];
    logic                     r_s2_valid;
    logic [NC-1:0][SQ_W-1:0]  r_s2_p;
    logic [NC-1:0]            r_s2_neg;
    logic                     r_s2_zero;
    logic [EA_W-1:0]          r_s2_ea;

    logic                     r_s3_valid;
    t_side                    r_s3;

    logic [tbs_pkg::ROOT_W-1:0] root;
    logic                     side_valid;
    t_side                    side;

    logic [tbs_pkg::DEN_W-1:0] den;
    logic [NC-1:0][tbs_pkg::NUMP_W-1:0] num;
    logic                     tail_valid;
    t_tail                    tail_in;
    t_tail                    tail;

    assign busy = 1'b0;

    // front: differences and E*A
    always_ff @(posedge i_clk) begin
        r_s1_d[0] <= {i_item.end_b_x[31], i_item.end_b_x}
                   - {i_item.end_a_x[31], i_item.end_a_x};
        r_s1_d[1] <= {i_item.end_b_y[31], i_item.end_b_y}
                   - {i_item.end_a_y[31], i_item.end_a_y};
        r_s1_d[2] <= {i_item.end_b_z[31], i_item.end_b_z}
                   - {i_item.end_a_z[31], i_item.end_a_z};
        r_s1_ea   <= EA_W'(i_item.modulus) * EA_W'(i_item.area);
    end

    for (genvar i = 0; i < 3; i++) begin : g_mag
        assign mag[i] = r_s1_d[i][DIFF_W-1] ? MAG_W'(-r_s1_d[i]) : MAG_W'(r_s1_d[i]);
    end

    // squares and cross products of the magnitudes, their signs and the zero-length flag
    always_ff @(posedge i_clk) begin
        r_s2_p[tbs_pkg::LANE_XX] <= SQ_W'(mag[0]) * SQ_W'(mag[0]);
        r_s2_p[tbs_pkg::LANE_YY] <= SQ_W'(mag[1]) * SQ_W'(mag[1]);
        r_s2_p[tbs_pkg::LANE_ZZ] <= SQ_W'(mag[2]) * SQ_W'(mag[2]);
        r_s2_p[tbs_pkg::LANE_XY] <= SQ_W'(mag[0]) * SQ_W'(mag[1]);
        r_s2_p[tbs_pkg::LANE_XZ] <= SQ_W'(mag[0]) * SQ_W'(mag[2]);
        r_s2_p[tbs_pkg::LANE_YZ] <= SQ_W'(mag[1]) * SQ_W'(mag[2]);
        r_s2_neg[tbs_pkg::LANE_XX] <= 1'b0;
        r_s2_neg[tbs_pkg::LANE_YY] <= 1'b0;
        r_s2_neg[tbs_pkg::LANE_ZZ] <= 1'b0;
        r_s2_neg[tbs_pkg::LANE_XY] <= (r_s1_d[0][DIFF_W-1] ^ r_s1_d[1][DIFF_W-1])
                                    && (r_s1_d[0] != '0) && (r_s1_d[1] != '0);
        r_s2_neg[tbs_pkg::LANE_XZ] <= (r_s1_d[0][DIFF_W-1] ^ r_s1_d[2][DIFF_W-1])
                                    && (r_s1_d[0] != '0) && (r_s1_d[2] != '0);
        r_s2_neg[tbs_pkg::LANE_YZ] <= (r_s1_d[1][DIFF_W-1] ^ r_s1_d[2][DIFF_W-1])
                                    && (r_s1_d[1] != '0) && (r_s1_d[2] != '0);
        r_s2_zero <= (r_s1_d[0] == '0) && (r_s1_d[1] == '0) && (r_s1_d[2] == '0);
        r_s2_ea   <= r_s1_ea;
    end

    // squared length
    always_ff @(posedge i_clk) begin
        r_s3.l2   <= L2_W'(r_s2_p[tbs_pkg::LANE_XX]) + L2_W'(r_s2_p[tbs_pkg::LANE_YY])
                   + L2_W'(r_s2_p[tbs_pkg::LANE_ZZ]);
        r_s3.ea   <= r_s2_ea;
        r_s3.p    <= r_s2_p;
        r_s3.neg  <= r_s2_neg;
        r_s3.zero <= r_s2_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    tbs_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_l2   (r_s3.l2),
        .o_root (root)
    );

    tbs_delay #(
        .WIDTH ($bits(t_side)),
        .DEPTH (tbs_pkg::ROOT_W)
    ) u_side_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_data  (r_s3),
        .o_valid (side_valid),
        .o_data  (side)
    );

    tbs_wmul #(
        .A_W (L2_W),
        .B_W (tbs_pkg::ROOT_W)
    ) u_den_mul (
        .i_clk (i_clk),
        .i_a   (side.l2),
        .i_b   (root),
        .o_p   (den)
    );

    for (genvar l = 0; l < NC; l++) begin : g_num
        tbs_wmul #(
            .A_W (EA_W),
            .B_W (SQ_W)
        ) u_num_mul (
            .i_clk (i_clk),
            .i_a   (side.ea),
            .i_b   (side.p[l]),
            .o_p   (num[l])
        );
    end

    assign tail_in.neg  = side.neg;
    assign tail_in.zero = side.zero;

    tbs_delay #(
        .WIDTH ($bits(t_tail)),
        .DEPTH (tbs_pkg::MUL_LAT)
    ) u_tail_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (side_valid),
        .i_data  (tail_in),
        .o_valid (tail_valid),
        .o_data  (tail)
    );

    tbs_div #(
        .SHIFT (SHIFT)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (tail_valid),
        .i_num    (num),
        .i_den    (den),
        .i_neg    (tail.neg),
        .i_zero   (tail.zero),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/tbs_check.sv =====
// Port-level checker for truss_bar_stiffness, attached by bind.
// Depends on tbs_pkg.
`default_nettype none

module tbs_check (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire tbs_pkg::t_result o_result
);

    localparam logic [63:0] POS_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] NEG_MIN = {1'b1, {63{1'b0}}};

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(tbs_pkg::PIPE_LAT) o_valid)
        else $error("request did not produce a result on time");

    a_zero_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_length) |->
            (o_result.coef_xx == '0 && o_result.coef_yy == '0 &&
             o_result.coef_zz == '0 && o_result.coef_xy == '0 &&
             o_result.coef_xz == '0 && o_result.coef_yz == '0 &&
             !o_result.saturated))
        else $error("zero-length bar with nonzero coefficients or flag");

    a_diag_sign : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_result.coef_xx[63] && !o_result.coef_yy[63] &&
                     !o_result.coef_zz[63]))
        else $error("diagonal coefficient negative");

    a_sat_clamp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.coef_xx == POS_MAX || o_result.coef_yy == POS_MAX ||
             o_result.coef_zz == POS_MAX ||
             o_result.coef_xy == POS_MAX || o_result.coef_xy == NEG_MIN ||
             o_result.coef_xz == POS_MAX || o_result.coef_xz == NEG_MIN ||
             o_result.coef_yz == POS_MAX || o_result.coef_yz == NEG_MIN))
        else $error("saturated flag without a clamped coefficient");

endmodule

bind truss_bar_stiffness tbs_check u_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
